// ----- hdl/tlpap_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpap_pkg: shared types and constants of the PAp branch predictor
// Table geometry, counter encodings, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlpap_pkg;

  // Geometry: per-branch histories and per-address pattern tables
  localparam int HIST_BITS      = 6;
  localparam int HIST_ENTRIES   = 512;
  localparam int HIST_SLOT_BITS = $clog2(HIST_ENTRIES);
  localparam int PAT_TABLES     = 8;
  localparam int TABLE_BITS     = $clog2(PAT_TABLES);
  localparam int CTR_ENTRIES    = PAT_TABLES << HIST_BITS;
  localparam int CTR_IDX_BITS   = TABLE_BITS + HIST_BITS;

  // Clearing pass covers the deeper of the two tables
  localparam int CLEAR_DEPTH = (HIST_ENTRIES > CTR_ENTRIES) ? HIST_ENTRIES : CTR_ENTRIES;
  localparam int CLEAR_BITS  = $clog2(CLEAR_DEPTH);

  // Two-bit saturating counter codes
  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  // Stream widths
  localparam int PC_BITS    = 32;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic clear_wr;   // write reset values at the clear pointer
    logic load_item;  // capture the input transaction, read its history
    logic ctr_rd;     // read the selected counter
    logic resolve;    // publish prediction, train on update
  } cmd_t;

  typedef struct packed {
    logic clear_last; // clear pointer at the last entry
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

// ----- hdl/tlpap_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlpap_ctrl: sequencing controller of the PAp branch predictor
// Runs the clearing pass after reset, then steps each input transaction
// through history read, counter read and resolve.
// ----------------------------------------------------------------------------
module tlpap_ctrl
  import tlpap_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  status_t status,
  output logic    s_tready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.ctr_rd = 1'b1;
        state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.resolve = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hdl/tlpap_datapath.sv -----
// ----------------------------------------------------------------------------
// tlpap_datapath: tables and result register of the PAp branch predictor
// Holds the history and pattern tables, the captured transaction, the
// counter update logic and the output register.
// ----------------------------------------------------------------------------
module tlpap_datapath
  import tlpap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic                 s_mode,
  input  logic [PC_BITS-1:0]   s_pc,
  input  logic                 s_taken,
  input  logic                 m_tready,
  output status_t              status,
  output logic                 m_tvalid,
  output logic                 predict_taken
);

  logic [HIST_BITS-1:0]      hist_mem [HIST_ENTRIES];
  logic [1:0]                ctr_mem  [CTR_ENTRIES];

  logic [CLEAR_BITS-1:0]     clear_addr;
  logic [HIST_SLOT_BITS-1:0] slot;
  logic [TABLE_BITS-1:0]     table_sel;
  logic                      mode;
  logic                      taken;
  logic [HIST_BITS-1:0]      hist_rd;
  logic [1:0]                ctr_rd;
  logic [1:0]                ctr_next;
  logic [HIST_BITS-1:0]      hist_next;
  logic [CTR_IDX_BITS-1:0]   ctr_idx;
  logic                      update_wr;

  // Clearing pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign status.clear_last = (clear_addr == CLEAR_BITS'(CLEAR_DEPTH - 1));
  assign status.out_free   = !m_tvalid || m_tready;

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      slot      <= s_pc[TABLE_BITS +: HIST_SLOT_BITS];
      table_sel <= s_pc[TABLE_BITS-1:0];
      mode      <= s_mode;
      taken     <= s_taken;
    end
  end

  assign ctr_idx   = {table_sel, hist_rd};
  assign update_wr = cmd.resolve && mode;
  assign hist_next = {hist_rd[HIST_BITS-2:0], taken};

  // Saturating counter step
  always_comb begin
    ctr_next = ctr_rd;
    if (taken) begin
      if (ctr_rd != CTR_STRONG_T) begin
        ctr_next = ctr_rd + 2'd1;
      end
    end else begin
      if (ctr_rd != CTR_STRONG_NT) begin
        ctr_next = ctr_rd - 2'd1;
      end
    end
  end

  // History table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      if (int'(clear_addr) < HIST_ENTRIES) begin
        hist_mem[clear_addr[HIST_SLOT_BITS-1:0]] <= '0;
      end
    end else if (update_wr) begin
      hist_mem[slot] <= hist_next;
    end
    if (cmd.load_item) begin
      hist_rd <= hist_mem[s_pc[TABLE_BITS +: HIST_SLOT_BITS]];
    end
  end

  // Pattern tables: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      if (int'(clear_addr) < CTR_ENTRIES) begin
        ctr_mem[clear_addr[CTR_IDX_BITS-1:0]] <= CTR_WEAK_NT;
      end
    end else if (update_wr) begin
      ctr_mem[ctr_idx] <= ctr_next;
    end
    if (cmd.ctr_rd) begin
      ctr_rd <= ctr_mem[ctr_idx];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.resolve) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      predict_taken <= (ctr_rd >= CTR_WEAK_T);
    end
  end

endmodule

// ----- hdl/two_level_pap_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// two_level_pap_branch_predictor: per-address two-level branch predictor
// Flow: each input transaction passes through a dependent history read, counter
// read and resolve step with write-back; the resolve step waits while the output
// register holds an unaccepted result, and no new input is taken until it resolves.
// Reset: a clearing pass zeroes the histories and sets every counter to
// weakly not taken; no input is taken until it finishes.
// ----------------------------------------------------------------------------
module two_level_pap_branch_predictor
  import tlpap_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] pc, [32] taken, rest zero
  input  logic                 s_tuser,  // [0] mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata   // [0] predict_taken, rest zero
);

  cmd_t    cmd;
  status_t status;
  logic    predict_taken;

  tlpap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  tlpap_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .s_mode        (s_tuser),
    .s_pc          (s_tdata[PC_BITS-1:0]),
    .s_taken       (s_tdata[PC_BITS]),
    .m_tready      (m_tready),
    .status        (status),
    .m_tvalid      (m_tvalid),
    .predict_taken (predict_taken)
  );

  assign m_tdata = {{(M_TDATA_W-1){1'b0}}, predict_taken};

  // One transaction in flight: input closes right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a transaction is in flight");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.resolve |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten while stalled");

  // A result appears only from a resolve step
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.resolve))
    else $error("result valid without a resolve step");

  // No input during the clearing pass
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !s_tready)
    else $error("input open during clearing pass");

endmodule

// ----- test/two_level_pap_branch_predictor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_pap_branch_predictor_tb: self-checking bench for the PAp predictor
// Streams predict and update transactions through the block, tracks the
// per-branch histories and pattern counters alongside it, and checks each
// returned prediction in order, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module two_level_pap_branch_predictor_tb;
  import tlpap_pkg::*;

  localparam realtime CLK_HALF = 6ns;
  localparam int      RST_CYCLES = 12;
  localparam int      RANDOM_OPS = 400;
  localparam int      HOT_BRANCHES = 12;
  localparam int      QUIET_FROM = 150;
  localparam int      QUIET_TO = 260;
  localparam int      DRAIN_CYCLES = 12;
  localparam logic    MODE_PREDICT = 1'b0;
  localparam logic    MODE_UPDATE = 1'b1;

  typedef struct {
    logic        mode;
    logic [31:0] pc;
    logic        taken;
  } branch_op_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // [31:0] pc, [32] taken, rest zero
  logic                 s_tuser = 1'b0; // [0] mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // [0] predict_taken, rest zero

  branch_op_t  branch_ops[$];
  logic        predicted_dirs[$];
  logic [HIST_BITS-1:0] hist_regs[HIST_ENTRIES];
  logic [1:0]  ctr_regs[CTR_ENTRIES];
  logic        src_accepted = 1'b0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          n_total = 0;

  two_level_pap_branch_predictor DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 12 ns clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic flag_error(string what);
    $display("ERROR at %0t: %s", $time, what);
    n_errors++;
  endtask

  task automatic queue_op(logic mode, logic [31:0] pc, logic taken);
    branch_op_t op;
    op.mode = mode;
    op.pc = pc;
    op.taken = taken;
    branch_ops.push_back(op);
    n_total++;
  endtask

  // Drive input transactions at the falling edge; hold until accepted
  always @(negedge clk) begin : input_driver
    branch_op_t op;
    logic       pause;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || src_accepted) begin
      pause = !(n_sent >= QUIET_FROM && n_sent < QUIET_TO) &&
              ($urandom_range(0, 99) < 10);
      if (branch_ops.size() != 0 && !pause) begin
        op = branch_ops.pop_front();
        s_tdata <= {{(S_TDATA_W-33){1'b0}}, op.taken, op.pc};
        s_tuser <= op.mode;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, except for a quiet stretch
  always @(negedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= (n_checked >= QUIET_FROM && n_checked < QUIET_TO) ||
                  ($urandom_range(0, 99) >= 10);
  end

  // Predict each accepted transaction and train the shadow tables on updates
  always @(posedge clk) begin : branch_tracker
    logic [TABLE_BITS-1:0]     tbl;
    logic [HIST_SLOT_BITS-1:0] slot;
    logic [HIST_BITS-1:0]      hist;
    logic [CTR_IDX_BITS-1:0]   idx;
    logic [1:0]                ctr;
    logic                      taken;
    src_accepted <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      tbl = s_tdata[TABLE_BITS-1:0];
      slot = s_tdata[TABLE_BITS +: HIST_SLOT_BITS];
      taken = s_tdata[32];
      hist = hist_regs[slot];
      idx = {tbl, hist};
      ctr = ctr_regs[idx];
      predicted_dirs.push_back(ctr >= CTR_WEAK_T);
      if (s_tuser == MODE_UPDATE) begin
        if (taken && ctr != CTR_STRONG_T)
          ctr = ctr + 2'd1;
        else if (!taken && ctr != CTR_STRONG_NT)
          ctr = ctr - 2'd1;
        ctr_regs[idx] = ctr;
        hist_regs[slot] = {hist[HIST_BITS-2:0], taken};
      end
      n_sent++;
    end
  end

  // Compare each returned prediction with the oldest expectation
  always @(posedge clk) begin : result_checker
    logic want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_dirs.size() == 0) begin
        flag_error($sformatf("unexpected result transaction, tdata=%0h", m_tdata));
      end else begin
        want = predicted_dirs.pop_front();
        if (m_tdata[0] !== want)
          flag_error($sformatf("result %0d: predict_taken %b, expected %b",
                               n_checked, m_tdata[0], want));
      end
      n_checked++;
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    logic [11:0] hot_pcs[HOT_BRANCHES];
    int          bias[HOT_BRANCHES];
    int          k;
    int          r;
    logic [31:0] pc;

    for (int i = 0; i < HIST_ENTRIES; i++) hist_regs[i] = '0;
    for (int i = 0; i < CTR_ENTRIES; i++) ctr_regs[i] = CTR_WEAK_NT;

    // Cold lookups at the address extremes
    queue_op(MODE_PREDICT, 32'h0000_0000, 1'b0);
    queue_op(MODE_PREDICT, 32'hFFFF_FFFF, 1'b1);
    // Train a branch to always taken: history fills with ones, counter saturates high
    for (int i = 0; i < 10; i++) queue_op(MODE_UPDATE, 32'h0000_0FFF, 1'b1);
    queue_op(MODE_PREDICT, 32'hFFFF_FFFF, 1'b0);
    queue_op(MODE_PREDICT, 32'h0000_0FFF, 1'b1);
    // Train a branch to never taken: counter saturates at zero
    for (int i = 0; i < 4; i++) queue_op(MODE_UPDATE, 32'h0000_0123, 1'b0);
    queue_op(MODE_PREDICT, 32'hABCD_E123, 1'b1);
    // Alias through the ignored upper address bits
    queue_op(MODE_UPDATE, 32'hFFFF_F000, 1'b1);
    queue_op(MODE_PREDICT, 32'h0000_0000, 1'b0);
    queue_op(MODE_UPDATE, 32'h8000_0007, 1'b0);
    queue_op(MODE_PREDICT, 32'h7FFF_F007, 1'b1);

    // A handful of hot branches with fixed taken bias, plus random noise
    for (int i = 0; i < HOT_BRANCHES; i++) begin
      hot_pcs[i] = 12'($urandom_range(0, 4095));
      bias[i] = (i * 10) / (HOT_BRANCHES - 1);
    end
    hot_pcs[0] = 12'h000;
    hot_pcs[HOT_BRANCHES-1] = 12'hFFF;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      r = int'($urandom_range(0, 99));
      if (r < 15) begin
        queue_op(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
      end else begin
        k = int'($urandom_range(0, HOT_BRANCHES - 1));
        pc = ($urandom() & 32'hFFFF_F000) | {20'd0, hot_pcs[k]};
        queue_op(($urandom_range(0, 99) < 75) ? MODE_UPDATE : MODE_PREDICT, pc,
                 $urandom_range(0, 9) < bias[k]);
      end
    end

    repeat (RST_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Wait for every transaction to go in and every result to come back
    while (n_sent < n_total || predicted_dirs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(CLK_HALF * 2 * 200000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
